// File: rtl/ultrasonic_echo_ranger_defines.svh
// Assertion macros shared by the echo ranger checker.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Checked on every edge outside reset.
`define URNG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define URNG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/urng_pkg.sv
// Types and constants shared by the echo ranger modules.
`timescale 1ns / 1ps
`default_nettype none

package urng_pkg;

  // Measurement phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  // Register indexes (byte address / 4)
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_TRIGGER  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NEAR     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MID      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FAR      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FARTHEST = 3'd6;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned SCALE_W = 20;
  localparam int unsigned TMO_W   = 32;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned NUM_THR = 4;
  localparam int unsigned OUT_DIST_W = 16;

  // Fixed-point shift: Q16 scale plus halving of the round trip
  localparam int unsigned DIST_SHIFT = 17;

  // Reset values of the registers
  localparam logic [TRIG_W-1:0]  TRIGGER_RST = 16'd166;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 20'd1405;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST = 32'hFFFF_FFFF;
  localparam logic [THR_W-1:0]   NEAR_RST    = 16'd10;
  localparam logic [THR_W-1:0]   MID_RST     = 16'd500;
  localparam logic [THR_W-1:0]   FAR_RST     = 16'd1000;
  localparam logic [THR_W-1:0]   FARTHEST_RST = 16'd3000;

  typedef logic [NUM_THR-1:0][THR_W-1:0] thr_arr_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [SCALE_W-1:0] mm_per_tick_q16;
    logic [TMO_W-1:0]   timeout_ticks;
    thr_arr_t           thr;
  } cfg_t;

  // Per-tick status handed from the sequencer to the distance stage
  typedef struct packed {
    logic trigger;
    logic busy;
    logic done;
    logic fin_ok;
    logic fin_to;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: top level with config port, sequencer and distance stage.
// An accepted tick request passes the handoff, multiply and result registers in that order.
// Throughput: one tick per cycle unless stalled; sequencer updates in the accept cycle.
// The three internal stages advance together and hold while a result is stalled.
// Reset (synchronous, rst_n low): idle phase, counts, last distance, mask and flag cleared,
// registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int COUNT_BITS    = 32,
  parameter int DISTANCE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_start_req,
  input  logic                             in_echo,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_trigger,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic                             out_timed_out,
  output logic [urng_pkg::OUT_DIST_W-1:0]  out_distance_mm,
  output logic [urng_pkg::NUM_THR-1:0]     out_level_mask,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [urng_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [urng_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [urng_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import urng_pkg::*;

  cfg_t                  cfg;
  logic                  adv;
  logic                  valid_b;
  stat_t                 stat_b;
  logic [COUNT_BITS-1:0] count_b;

  // Whole pipeline moves unless a finished result is held by the sink
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  urng_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  urng_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_start_req (in_start_req),
    .in_echo      (in_echo),
    .cfg          (cfg),
    .valid_b_r    (valid_b),
    .stat_b_r     (stat_b),
    .count_b_r    (count_b)
  );

  urng_dist #(
    .COUNT_BITS    (COUNT_BITS),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_dist (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .cfg             (cfg),
    .valid_b         (valid_b),
    .stat_b          (stat_b),
    .count_b         (count_b),
    .out_valid       (out_valid),
    .out_trigger     (out_trigger),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_timed_out   (out_timed_out),
    .out_distance_mm (out_distance_mm),
    .out_level_mask  (out_level_mask)
  );

endmodule

`default_nettype wire

// File: rtl/urng_regs.sv
// APB-style configuration register file for the echo ranger.
`timescale 1ns / 1ps
`default_nettype none

module urng_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [urng_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [urng_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [urng_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output urng_pkg::cfg_t               cfg
);
  import urng_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  cfg_t                 cfg_r;

  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks   <= TRIGGER_RST;
      cfg_r.mm_per_tick_q16 <= SCALE_RST;
      cfg_r.timeout_ticks   <= TIMEOUT_RST;
      cfg_r.thr[0]          <= NEAR_RST;
      cfg_r.thr[1]          <= MID_RST;
      cfg_r.thr[2]          <= FAR_RST;
      cfg_r.thr[3]          <= FARTHEST_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TRIGGER:  cfg_r.trigger_ticks   <= cfg_pwdata[TRIG_W-1:0];
        REG_SCALE:    cfg_r.mm_per_tick_q16 <= cfg_pwdata[SCALE_W-1:0];
        REG_TIMEOUT:  cfg_r.timeout_ticks   <= cfg_pwdata[TMO_W-1:0];
        REG_NEAR:     cfg_r.thr[0]          <= cfg_pwdata[THR_W-1:0];
        REG_MID:      cfg_r.thr[1]          <= cfg_pwdata[THR_W-1:0];
        REG_FAR:      cfg_r.thr[2]          <= cfg_pwdata[THR_W-1:0];
        REG_FARTHEST: cfg_r.thr[3]          <= cfg_pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_TRIGGER:  cfg_prdata = DATA_W'(cfg_r.trigger_ticks);
      REG_SCALE:    cfg_prdata = DATA_W'(cfg_r.mm_per_tick_q16);
      REG_TIMEOUT:  cfg_prdata = DATA_W'(cfg_r.timeout_ticks);
      REG_NEAR:     cfg_prdata = DATA_W'(cfg_r.thr[0]);
      REG_MID:      cfg_prdata = DATA_W'(cfg_r.thr[1]);
      REG_FAR:      cfg_prdata = DATA_W'(cfg_r.thr[2]);
      REG_FARTHEST: cfg_prdata = DATA_W'(cfg_r.thr[3]);
      default:      cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/urng_ctrl.sv
// Measurement sequencer: trigger, echo wait and echo-high tick counting.
`timescale 1ns / 1ps
`default_nettype none

module urng_ctrl #(
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic                   in_start_req,
  input  logic                   in_echo,
  input  urng_pkg::cfg_t         cfg,
  output logic                   valid_b_r,
  output urng_pkg::stat_t        stat_b_r,
  output logic [COUNT_BITS-1:0]  count_b_r
);
  import urng_pkg::*;

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic [1:0]            phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                  echo_prev_r;
  logic                  take;
  stat_t                 stat;

  assign take    = adv && in_valid;
  assign cnt_inc = (cnt_r == CMAX) ? cnt_r : cnt_r + COUNT_BITS'(1);

  // Next-state logic for one tick
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    stat.done   = 1'b0;
    stat.fin_ok = 1'b0;
    stat.fin_to = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (in_start_req) begin
          phase_nxt = PH_TRIG;
          cnt_nxt   = '0;
        end
      end
      PH_TRIG: begin
        cnt_nxt = cnt_inc;
        if (32'(cnt_inc) >= 32'(cfg.trigger_ticks)) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end
      end
      PH_WAIT: begin
        if (in_echo && !echo_prev_r) begin
          cnt_nxt   = COUNT_BITS'(1);
          phase_nxt = PH_MEAS;
          // a count of one already reaches a timeout of zero or one
          if (cfg.timeout_ticks <= 32'd1) begin
            stat.fin_to = 1'b1;
            stat.done   = 1'b1;
            phase_nxt   = PH_IDLE;
          end
        end
      end
      default: begin
        if (in_echo) begin
          cnt_nxt = cnt_inc;
          if (32'(cnt_inc) >= cfg.timeout_ticks || cnt_inc == CMAX) begin
            stat.fin_to = 1'b1;
            stat.done   = 1'b1;
            phase_nxt   = PH_IDLE;
          end
        end else begin
          stat.fin_ok = 1'b1;
          stat.done   = 1'b1;
          phase_nxt   = PH_IDLE;
        end
      end
    endcase
    stat.trigger = (phase_nxt == PH_TRIG);
    stat.busy    = (phase_nxt != PH_IDLE);
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      echo_prev_r <= 1'b0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      echo_prev_r <= in_echo;
    end
  end

  // Handoff register to the distance stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (adv) begin
      valid_b_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stat_b_r  <= stat;
      count_b_r <= cnt_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/urng_dist.sv
// Distance scaling, saturation, level mask and result register.
`timescale 1ns / 1ps
`default_nettype none

module urng_dist #(
  parameter int COUNT_BITS    = 32,
  parameter int DISTANCE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  urng_pkg::cfg_t                    cfg,
  input  logic                              valid_b,
  input  urng_pkg::stat_t                   stat_b,
  input  logic [COUNT_BITS-1:0]             count_b,
  output logic                              out_valid,
  output logic                              out_trigger,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic                              out_timed_out,
  output logic [urng_pkg::OUT_DIST_W-1:0]   out_distance_mm,
  output logic [urng_pkg::NUM_THR-1:0]      out_level_mask
);
  import urng_pkg::*;

  localparam int PROD_W = COUNT_BITS + SCALE_W;
  localparam int SH_W   = PROD_W - DIST_SHIFT;
  localparam int WIDE_W = (SH_W > DISTANCE_BITS) ? SH_W : DISTANCE_BITS;
  localparam int CMP_W  = (DISTANCE_BITS > THR_W) ? DISTANCE_BITS : THR_W;
  localparam logic [WIDE_W-1:0] DMAX = WIDE_W'({DISTANCE_BITS{1'b1}});

  logic                     valid_c_r;
  stat_t                    stat_c_r;
  logic [PROD_W-1:0]        prod_c_r;
  logic [WIDE_W-1:0]        sh_w, sat_w;
  logic [DISTANCE_BITS-1:0] dist_sat;
  logic [NUM_THR-1:0]       mask;
  logic                     out_valid_r, timed_out_r;
  logic                     trigger_r, busy_r, done_r;
  logic [OUT_DIST_W-1:0]    dist_r;
  logic [NUM_THR-1:0]       mask_r;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_c_r <= 1'b0;
    end else if (adv) begin
      valid_c_r <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_b) begin
      stat_c_r <= stat_b;
      prod_c_r <= PROD_W'(count_b) * PROD_W'(cfg.mm_per_tick_q16);
    end
  end

  // Shift, saturate and compare against the four thresholds
  always_comb begin
    sh_w     = WIDE_W'(prod_c_r >> DIST_SHIFT);
    sat_w    = (sh_w > DMAX) ? DMAX : sh_w;
    dist_sat = sat_w[DISTANCE_BITS-1:0];
    for (int i = 0; i < NUM_THR; i++) begin
      mask[i] = CMP_W'(dist_sat) > CMP_W'(cfg.thr[i]);
    end
  end

  // Result register, also holds the last distance, mask and timeout flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      timed_out_r <= 1'b0;
      dist_r      <= '0;
      mask_r      <= '0;
    end else if (adv) begin
      out_valid_r <= valid_c_r;
      if (valid_c_r && stat_c_r.fin_ok) begin
        dist_r      <= OUT_DIST_W'(dist_sat);
        mask_r      <= mask;
        timed_out_r <= 1'b0;
      end else if (valid_c_r && stat_c_r.fin_to) begin
        mask_r      <= '0;
        timed_out_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_c_r) begin
      trigger_r <= stat_c_r.trigger;
      busy_r    <= stat_c_r.busy;
      done_r    <= stat_c_r.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger     = trigger_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_timed_out   = timed_out_r;
  assign out_distance_mm = dist_r;
  assign out_level_mask  = mask_r;

endmodule

`default_nettype wire

// File: rtl/urng_checker.sv
// Port-level checker for the echo ranger and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "ultrasonic_echo_ranger_defines.svh"

module urng_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_trigger,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [15:0] out_distance_mm,
  input logic [3:0]  out_level_mask
);

  // A stalled result keeps its contents
  `URNG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_distance_mm) && $stable(out_level_mask) && $stable(out_done_res), "stalled result changed")

  // Input is held off only while a result is backed up
  `URNG_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a held result")

  // Trigger is driven only during a measurement
  `URNG_ASSERT(a_trig_busy, out_valid && out_trigger |-> out_busy_res, "trigger high while idle")

  // A finished measurement leaves the block idle
  `URNG_ASSERT(a_done_idle, out_valid && out_done_res |-> !out_busy_res, "done while still busy")

  // Reset empties the result register
  `URNG_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind ultrasonic_echo_ranger urng_checker u_chk (.*);

`default_nettype wire
